[hw/rtl/tei_pkg.sv]
// Shared widths, flag bundle and per-edge decision for the triangle edge test.
`timescale 1ns / 1ps
`default_nettype none

package tei_pkg;

  localparam int COORD_BITS = 21;
  localparam int VERTEX_W   = 63;
  localparam int TOL_W      = 20;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(168);

  // Exact growth through the datapath: diff, cross term, cross, triple term, dot.
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int TRIP_W  = CROSS_W + DIFF_W;
  localparam int DOT_W   = TRIP_W + 2;
  localparam int CMP_W   = DOT_W + 1;

  // Register stages from accept to result strobe.
  localparam int NUM_STAGES = 8;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [CROSS_W-1:0]    cross_t;
  typedef logic signed [TRIP_W-1:0]     trip_t;
  typedef logic signed [DOT_W-1:0]      dot_t;
  typedef logic signed [CMP_W-1:0]      cmp_t;

  // Sign classes against the dead zone, plus the two sum compares per branch.
  typedef struct packed {
    logic wpos;  // w >  tol
    logic wneg;  // w < -tol
    logic spos;
    logic sneg;
    logic tpos;
    logic tneg;
    logic upos;  // u = -(m.b)
    logic uneg;
    logic wlt;   // w < s+t+u
    logic wgt;   // w > s+t+u
    logic sgt;   // s > t+u
    logic slt;   // s < t+u
  } tei_flags_t;

  // Near-zero w uses m = d x a, i.e. t and u negated, folded into the flags.
  function automatic logic edge_hit(tei_flags_t f);
    logic h;
    if (f.wpos) begin
      h = !f.spos && !f.tneg && !f.uneg && !f.wlt;
    end else if (f.wneg) begin
      h = !f.sneg && !f.tpos && !f.upos && !f.wgt;
    end else if (f.spos) begin
      h = !f.tpos && !f.upos && !f.sgt;
    end else if (f.sneg) begin
      h = !f.tneg && !f.uneg && !f.slt;
    end else begin
      h = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tei_edge_check.sv]
// Per-edge classification: dead-zone compares, then the sum compares (two stages).
`timescale 1ns / 1ps
`default_nettype none

module tei_edge_check import tei_pkg::*; (
  input  logic             clk_i,
  input  dot_t             w_i,
  input  dot_t             s_i,
  input  dot_t             t_i,
  input  dot_t             mb_i,
  input  logic [TOL_W-1:0] tol_i,
  output tei_flags_t       flags_o
);

  dot_t       pos_tol;
  dot_t       neg_tol;
  tei_flags_t fa_d, fa_q;
  cmp_t       ws_d, ws_q;
  cmp_t       tu_d, tu_q;
  cmp_t       s_d, s_q;
  tei_flags_t fb_d, fb_q;

  assign pos_tol = dot_t'({{(DOT_W-TOL_W){1'b0}}, tol_i});
  assign neg_tol = -pos_tol;

  // Stage A: classify each triple product, form w-s and t+u (u = -mb).
  always_comb begin
    fa_d      = '0;
    fa_d.wpos = w_i > pos_tol;
    fa_d.wneg = w_i < neg_tol;
    fa_d.spos = s_i > pos_tol;
    fa_d.sneg = s_i < neg_tol;
    fa_d.tpos = t_i > pos_tol;
    fa_d.tneg = t_i < neg_tol;
    fa_d.upos = mb_i < neg_tol;
    fa_d.uneg = mb_i > pos_tol;
  end

  assign ws_d = CMP_W'(w_i) - CMP_W'(s_i);
  assign tu_d = CMP_W'(t_i) - CMP_W'(mb_i);
  assign s_d  = CMP_W'(s_i);

  always_ff @(posedge clk_i) begin
    fa_q <= fa_d;
    ws_q <= ws_d;
    tu_q <= tu_d;
    s_q  <= s_d;
  end

  // Stage B: w vs s+t+u and s vs t+u.
  always_comb begin
    fb_d     = fa_q;
    fb_d.wlt = ws_q < tu_q;
    fb_d.wgt = ws_q > tu_q;
    fb_d.sgt = s_q > tu_q;
    fb_d.slt = s_q < tu_q;
  end

  always_ff @(posedge clk_i) begin
    fb_q <= fb_d;
  end

  assign flags_o = fb_q;

endmodule

`default_nettype wire

[hw/rtl/triangle_edge_intersection_test_top.sv]
// Top level: pipelined edge-of-ABC versus triangle-PQR crossing predicate.
//
//   channel  | signals                                    | direction
//   ---------+--------------------------------------------+----------
//   command  | start_i, busy_o, vertex_{a,b,c,p,q,r}_i     | in
//   result   | done_o, hit_o                              | out
//   config   | cfg_valid_i, cfg_ready_o, cfg_data_i (tol) | in
//
// One triangle pair per cycle; busy_o never rises. The path from the accepting
// edge to the done_o beat runs through the stages diff / cross multiply /
// cross add / dot multiply / dot add / two compare stages / decision.
// Reset clears the valid pipe and loads tolerance with 168; data regs are not reset.
// The result beat cannot be held off, so nothing ever stalls.
`timescale 1ns / 1ps
`default_nettype none

module triangle_edge_intersection_test_top import tei_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [VERTEX_W-1:0] vertex_a_i,
  input  logic [VERTEX_W-1:0] vertex_b_i,
  input  logic [VERTEX_W-1:0] vertex_c_i,
  input  logic [VERTEX_W-1:0] vertex_p_i,
  input  logic [VERTEX_W-1:0] vertex_q_i,
  input  logic [VERTEX_W-1:0] vertex_r_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [TOL_W-1:0]    cfg_data_i,
  output logic                done_o,
  output logic                hit_o
);

  // rel index: 0..2 = A,B,C minus R; 3 = P-R (b); 4 = Q-R (c)
  localparam int IDX_B = 3;
  localparam int IDX_C = 4;

  logic                  accept;
  logic [NUM_STAGES-1:0] vld_q;
  logic [TOL_W-1:0]      tol_q;

  logic [VERTEX_W-1:0] vin [6];
  coord_t              crd [6][3];

  diff_t  rel_d  [5][3];
  diff_t  rel_q  [5][3];
  diff_t  rel2_q [5][3];
  diff_t  rel3_q [5][3];
  // cross index: 0..2 = edge m = a x d, 3 = n = b x c
  prod_t  xp_d [4][3];
  prod_t  xn_d [4][3];
  prod_t  xp_q [4][3];
  prod_t  xn_q [4][3];
  cross_t cr_d [4][3];
  cross_t cr_q [4][3];
  trip_t  dp_d [3][3];
  trip_t  tp_d [3][3];
  trip_t  bp_d [3][3];
  trip_t  dp_q [3][3];
  trip_t  tp_q [3][3];
  trip_t  bp_q [3][3];
  dot_t   vd_d [3];
  dot_t   td_d [3];
  dot_t   bd_d [3];
  dot_t   vd_q [3];
  dot_t   td_q [3];
  dot_t   bd_q [3];

  tei_flags_t flags [3];
  logic       hit_d, hit_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tol_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NUM_STAGES-2:0], accept};
    end
  end

  assign vin[0] = vertex_a_i;
  assign vin[1] = vertex_b_i;
  assign vin[2] = vertex_c_i;
  assign vin[3] = vertex_p_i;
  assign vin[4] = vertex_q_i;
  assign vin[5] = vertex_r_i;

  // Stage 1: unpack and subtract R.
  for (genvar v = 0; v < 6; v++) begin : g_unpack
    for (genvar k = 0; k < 3; k++) begin : g_axis
      assign crd[v][k] = vin[v][k*COORD_BITS +: COORD_BITS];
    end
  end

  for (genvar v = 0; v < 5; v++) begin : g_rel
    for (genvar k = 0; k < 3; k++) begin : g_axis
      assign rel_d[v][k] = DIFF_W'(crd[v][k]) - DIFF_W'(crd[5][k]);
    end
  end

  always_ff @(posedge clk_i) begin
    rel_q <= rel_d;
  end

  // Stage 2: cross-product terms.
  for (genvar j = 0; j < 4; j++) begin : g_xprod
    localparam int XI = (j == 3) ? IDX_B : j;
    localparam int YI = (j == 3) ? IDX_C : (j + 1) % 3;
    for (genvar k = 0; k < 3; k++) begin : g_axis
      assign xp_d[j][k] = PROD_W'(rel_q[XI][(k+1)%3]) * PROD_W'(rel_q[YI][(k+2)%3]);
      assign xn_d[j][k] = PROD_W'(rel_q[XI][(k+2)%3]) * PROD_W'(rel_q[YI][(k+1)%3]);
    end
  end

  always_ff @(posedge clk_i) begin
    xp_q   <= xp_d;
    xn_q   <= xn_d;
    rel2_q <= rel_q;
  end

  // Stage 3: cross products.
  for (genvar j = 0; j < 4; j++) begin : g_cross
    for (genvar k = 0; k < 3; k++) begin : g_axis
      assign cr_d[j][k] = CROSS_W'(xp_q[j][k]) - CROSS_W'(xn_q[j][k]);
    end
  end

  always_ff @(posedge clk_i) begin
    cr_q   <= cr_d;
    rel3_q <= rel2_q;
  end

  // Stage 4: dot-product terms. vX.n for each vertex, m.c and m.b per edge.
  for (genvar e = 0; e < 3; e++) begin : g_dprod
    for (genvar k = 0; k < 3; k++) begin : g_axis
      assign dp_d[e][k] = TRIP_W'(rel3_q[e][k]) * TRIP_W'(cr_q[3][k]);
      assign tp_d[e][k] = TRIP_W'(cr_q[e][k]) * TRIP_W'(rel3_q[IDX_C][k]);
      assign bp_d[e][k] = TRIP_W'(cr_q[e][k]) * TRIP_W'(rel3_q[IDX_B][k]);
    end
  end

  always_ff @(posedge clk_i) begin
    dp_q <= dp_d;
    tp_q <= tp_d;
    bp_q <= bp_d;
  end

  // Stage 5: dot products.
  for (genvar e = 0; e < 3; e++) begin : g_dot
    assign vd_d[e] = DOT_W'(dp_q[e][0]) + DOT_W'(dp_q[e][1]) + DOT_W'(dp_q[e][2]);
    assign td_d[e] = DOT_W'(tp_q[e][0]) + DOT_W'(tp_q[e][1]) + DOT_W'(tp_q[e][2]);
    assign bd_d[e] = DOT_W'(bp_q[e][0]) + DOT_W'(bp_q[e][1]) + DOT_W'(bp_q[e][2]);
  end

  always_ff @(posedge clk_i) begin
    vd_q <= vd_d;
    td_q <= td_d;
    bd_q <= bd_d;
  end

  // Stages 6-7: per-edge flags. Edge e runs from vertex e to vertex (e+1) mod 3.
  for (genvar e = 0; e < 3; e++) begin : g_edge
    tei_edge_check u_check (
      .clk_i   (clk_i),
      .w_i     (vd_q[e]),
      .s_i     (vd_q[(e+1)%3]),
      .t_i     (td_q[e]),
      .mb_i    (bd_q[e]),
      .tol_i   (tol_q),
      .flags_o (flags[e])
    );
  end

  // Stage 8: decision.
  assign hit_d = edge_hit(flags[0]) || edge_hit(flags[1]) || edge_hit(flags[2]);

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
  end

  assign hit_o  = hit_q;
  assign done_o = vld_q[NUM_STAGES-1];

`ifndef SYNTHESIS
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##8 done_o)
    else $error("accepted beat did not produce a result after 8 cycles");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 8))
    else $error("result beat without a matching accepted beat");

  a_flags_sane : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NUM_STAGES-2] |-> !(flags[0].wlt && flags[0].wgt) && !(flags[0].sgt && flags[0].slt))
    else $error("contradictory compare flags on edge AB");
`endif

endmodule

`default_nettype wire
